FILE: rtl/core/sns_pkg.sv
package sns_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int FRACTION_BITS = 16;

    // accumulator / multiplier operand A
    localparam int ACC_W = 48;
    // operand B must hold a 17-bit coefficient, the low and high halves of v
    localparam int MB_0    = (FRACTION_BITS + 1 > 18) ? FRACTION_BITS + 1 : 18;
    localparam int MUL_B_W = (33 - FRACTION_BITS > MB_0) ? 33 - FRACTION_BITS : MB_0;
    localparam int PROD_W  = ACC_W + MUL_B_W;

    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + 32 + 32 + 7) / 8) * 8;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [ACC_W:0]     wide_t;
    typedef logic signed [MUL_B_W-1:0] mb_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [SAMPLE_BITS-1:0]    sample_t;

    localparam longint ONE = longint'(1) << FRACTION_BITS;

    localparam mb_t   K_QUAD    = mb_t'((4 * ONE + 50) / 100);
    localparam acc_t  BIAS      = acc_t'(140 * ONE);
    localparam acc_t  CLAMP_POS = acc_t'((longint'(1) << 46) - 1);
    localparam acc_t  CLAMP_NEG = -CLAMP_POS;

    // register reset values
    localparam logic        [22:0] GAIN_RST  = 23'((ONE * 1000 * 10000) / 1713525);
    localparam logic        [16:0] STEP_RST  = 17'((5 * ONE + 50) / 100);
    localparam logic        [16:0] RATE_RST  = 17'((2 * ONE + 50) / 100);
    localparam logic        [16:0] SENS_RST  = 17'((20 * ONE + 50) / 100);
    localparam logic signed [23:0] C_RST     = 24'(-65 * ONE);
    localparam logic        [21:0] JUMP_RST  = 22'(8 * ONE);
    localparam logic        [23:0] THR_RST   = 24'(30 * ONE);
    localparam logic signed [23:0] FLOOR_RST = 24'(-30 * ONE);

    // neuron state reset values
    localparam sample_t            PREV_RST = sample_t'((66 * ((1 << SAMPLE_BITS) - 1) + 50) / 100);
    localparam logic signed [31:0] MEM_RST  = 32'(-30 * ONE);

    typedef enum logic [2:0] {
        CFG_GAIN,
        CFG_STEP,
        CFG_RATE,
        CFG_SENS,
        CFG_RESET_POT,
        CFG_JUMP,
        CFG_THRESHOLD,
        CFG_FLOOR
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T1,
        ST_CUR,
        ST_QLO,
        ST_QHI,
        ST_BV,
        ST_DV,
        ST_M1,
        ST_CLIP,
        ST_M2,
        ST_UN,
        ST_JUMP,
        ST_DONE
    } step_t;

    typedef struct packed {
        step_t step;
        logic  accept;
        logic  commit;
    } sns_ctrl_t;

    // product >> FRACTION_BITS, rounding toward minus infinity
    function automatic acc_t floor_shift(input prod_t p);
        prod_t t;
        t = p >>> FRACTION_BITS;
        return t[ACC_W-1:0];
    endfunction

    function automatic acc_t clamp46(input acc_t x);
        acc_t r;
        r = x;
        if (x > CLAMP_POS) r = CLAMP_POS;
        if (x < CLAMP_NEG) r = CLAMP_NEG;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t x);
        logic signed [31:0] r;
        if ((&x[ACC_W:31]) || !(|x[ACC_W:31])) begin
            r = x[31:0];
        end else if (x[ACC_W]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/sns_mul.sv
module sns_mul import sns_pkg::*; (
    input  logic  aclk,
    input  acc_t  op_a,
    input  mb_t   op_b,
    output prod_t prod
);

    prod_t prod_reg;

    // signed 48x18, registered
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/sns_seq.sv
module sns_seq import sns_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      out_free,
    output sns_ctrl_t ctrl
);

    step_t state_reg;
    step_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ctrl.step   = state_reg;
        ctrl.accept = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.accept = 1'b1;
                    state_next  = ST_T1;
                end
            end
            ST_T1:   state_next = ST_CUR;
            ST_CUR:  state_next = ST_QLO;
            ST_QLO:  state_next = ST_QHI;
            ST_QHI:  state_next = ST_BV;
            ST_BV:   state_next = ST_DV;
            ST_DV:   state_next = ST_M1;
            ST_M1:   state_next = ST_CLIP;
            ST_CLIP: state_next = ST_M2;
            ST_M2:   state_next = ST_UN;
            ST_UN:   state_next = ST_JUMP;
            ST_JUMP: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !s_tvalid) |=> state_reg == ST_IDLE)
        else $error("sequencer left idle without a request");

    a_steps_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_DONE) |=> state_reg != $past(state_reg))
        else $error("sequencer stalled inside a step");

    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> state_reg == ST_IDLE)
        else $error("commit did not return to idle");

endmodule

FILE: rtl/core/spiking_neuron_from_sensor_slope_top.sv
// Izhikevich-type spiking neuron driven by the slope of a 10-bit sensor sample.
// Each request carries one sample; the input current is current_gain times the
// change from the previous sample, then one forward-Euler step of v and u is
// taken in signed Q16.16 (products floor-rounded, v and u saturated to 32 bits).
// v is clamped up to potential_floor; reaching spike_threshold resets v to
// reset_potential, adds recovery_jump to u and flags a spike. One result per
// request: the sequencer steps from T1 through JUMP to DONE, then commits the
// result to the output register and returns to idle, so the next request is
// taken only after the last is committed. One shared 48x18 signed multiplier
// (registered product) forms all eight products of the step in turn, with
// a 48-bit accumulator gathering the potential derivative. s_tready is high only
// while the sequencer is idle; a finished result sits in an output register
// while the next sample is taken, and the block waits at the end of a step only
// if that register still holds an untaken result. Registers are written through
// cfg_we/cfg_addr/cfg_wdata in the order gain, step, a, b, c, d, threshold,
// floor; write them only while no sample is in flight. After reset, v = -30,
// u = 0, previous sample = 675.
module spiking_neuron_from_sensor_slope_top import sns_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: [9:0] adc_sample
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [0] spike, [32:1] membrane_out, [64:33] recovery_out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic        [22:0] gain_reg;
    logic        [16:0] step_reg;
    logic        [16:0] rate_reg;
    logic        [16:0] sens_reg;
    logic signed [23:0] rst_pot_reg;
    logic        [21:0] jump_reg;
    logic        [23:0] thr_reg;
    logic signed [23:0] floor_reg;

    // neuron state
    sample_t            prev_reg;
    logic signed [31:0] membrane_reg;
    logic signed [31:0] recovery_reg;

    // working registers for one step
    logic signed [SAMPLE_BITS:0] diff_reg;
    acc_t               acc_reg;     // dv/dt sum
    logic signed [31:0] t1_reg;      // floor(K*v)
    logic signed [34:0] bu_reg;      // b*v - u
    acc_t               m1_reg;      // a*(b*v - u)
    logic signed [31:0] vn_reg;
    logic signed [31:0] un_reg;
    logic               spike_reg;

    // output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_tdata_reg;

    sns_ctrl_t ctrl;
    logic      out_free;
    acc_t      op_a;
    mb_t       op_b;
    prod_t     prod;
    acc_t      prod_fs;
    sample_t   sample;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign prod_fs  = floor_shift(prod);

    sns_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    sns_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RST;
            step_reg    <= STEP_RST;
            rate_reg    <= RATE_RST;
            sens_reg    <= SENS_RST;
            rst_pot_reg <= C_RST;
            jump_reg    <= JUMP_RST;
            thr_reg     <= THR_RST;
            floor_reg   <= FLOOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GAIN:      gain_reg    <= cfg_wdata[22:0];
                CFG_STEP:      step_reg    <= cfg_wdata[16:0];
                CFG_RATE:      rate_reg    <= cfg_wdata[16:0];
                CFG_SENS:      sens_reg    <= cfg_wdata[16:0];
                CFG_RESET_POT: rst_pot_reg <= cfg_wdata;
                CFG_JUMP:      jump_reg    <= cfg_wdata[21:0];
                CFG_THRESHOLD: thr_reg     <= cfg_wdata;
                CFG_FLOOR:     floor_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // multiplier operand select; each product lands in prod in the next cycle
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (ctrl.step)
            ST_T1: begin                     // K * v
                op_a = acc_t'(membrane_reg);
                op_b = K_QUAD;
            end
            ST_CUR: begin                    // gain * sample difference
                op_a = acc_t'(gain_reg);
                op_b = mb_t'(diff_reg);
            end
            ST_QLO: begin                    // t1 * low fraction bits of v
                op_a = acc_t'(t1_reg);
                op_b = mb_t'(membrane_reg[FRACTION_BITS-1:0]);
            end
            ST_QHI: begin                    // t1 * integer part of v
                op_a = acc_t'(t1_reg);
                op_b = mb_t'(membrane_reg >>> FRACTION_BITS);
            end
            ST_BV: begin                     // b * v
                op_a = acc_t'(membrane_reg);
                op_b = mb_t'(sens_reg);
            end
            ST_DV: begin                     // dt * dv/dt
                op_a = clamp46(acc_reg);
                op_b = mb_t'(step_reg);
            end
            ST_M1: begin                     // a * (b*v - u)
                op_a = clamp46(acc_t'(bu_reg));
                op_b = mb_t'(rate_reg);
            end
            ST_M2: begin                     // dt * a*(b*v - u)
                op_a = clamp46(m1_reg);
                op_b = mb_t'(step_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // step datapath
    always_ff @(posedge aclk) begin
        case (ctrl.step)
            ST_IDLE: begin
                if (ctrl.accept) begin
                    diff_reg <= $signed({1'b0, sample}) - $signed({1'b0, prev_reg});
                    // 5v + 140 - u
                    acc_reg  <= (acc_t'(membrane_reg) <<< 2) + acc_t'(membrane_reg)
                                + BIAS - acc_t'(recovery_reg);
                end
            end
            ST_CUR:  t1_reg  <= prod_fs[31:0];
            ST_QLO:  acc_reg <= acc_reg + acc_t'(prod);      // current
            ST_QHI:  acc_reg <= acc_reg + prod_fs;           // low part of 0.04 v^2
            ST_BV:   acc_reg <= acc_reg + acc_t'(prod);      // high part, exact
            ST_DV: begin
                bu_reg <= 35'(prod_fs - acc_t'(recovery_reg));
            end
            ST_M1: begin
                vn_reg <= sat32(wide_t'(membrane_reg) + wide_t'(prod_fs));
            end
            ST_CLIP: begin
                m1_reg <= prod_fs;
                if (vn_reg < 32'(floor_reg)) begin
                    vn_reg <= 32'(floor_reg);
                end
            end
            ST_M2: begin
                if ($signed({vn_reg[31], vn_reg}) >= $signed({9'b0, thr_reg})) begin
                    spike_reg <= 1'b1;
                    vn_reg    <= 32'(rst_pot_reg);
                end else begin
                    spike_reg <= 1'b0;
                end
            end
            ST_UN: begin
                un_reg <= sat32(wide_t'(recovery_reg) + wide_t'(prod_fs));
            end
            ST_JUMP: begin
                if (spike_reg) begin
                    un_reg <= sat32(wide_t'(un_reg) + wide_t'(jump_reg));
                end
            end
            default: ;
        endcase
    end

    // neuron state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= PREV_RST;
            membrane_reg  <= MEM_RST;
            recovery_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                prev_reg <= sample;
            end
            if (ctrl.commit) begin
                membrane_reg  <= vn_reg;
                recovery_reg  <= un_reg;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            out_tdata_reg <= {{(M_TDATA_W - 65){1'b0}}, un_reg, vn_reg, spike_reg};
        end
    end

    // no request is taken while reset is held
    assign s_tready = aresetn && (ctrl.step == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step == ST_DONE && !ctrl.commit)
            |=> $stable(out_tdata_reg) && $stable(membrane_reg) && $stable(recovery_reg))
        else $error("state or result changed while waiting for output slot");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("waiting result dropped or changed");

endmodule

FILE: tb/spiking_neuron_from_sensor_slope_top_tb.sv
`timescale 1ns / 100ps

module spiking_neuron_from_sensor_slope_top_tb import sns_pkg::*; ();

    // result of one neuron step, as it travels on m_tdata
    typedef struct packed {
        logic               spike;
        logic signed [31:0] membrane;
        logic signed [31:0] recovery;
    } neuron_out_t;

    typedef enum logic { ROW_SAMPLE, ROW_REG } row_kind_t;

    // register settings used per random phase
    typedef enum logic [1:0] { PROF_NOMINAL, PROF_EXTREME, PROF_RANDOM } profile_t;

    // directed table row: either a register write or a sample request
    typedef struct packed {
        row_kind_t   kind;
        cfg_idx_t    reg_idx;
        logic [23:0] value;
        logic [9:0]  sample;
        logic [2:0]  known;   // fields typed into the row: [0] spike, [1] membrane, [2] recovery
        neuron_out_t want;
    } row_t;

    localparam logic [2:0] KNOWN_NONE    = 3'b000;
    localparam logic [2:0] KNOWN_SPIKE_V = 3'b011;
    localparam logic [2:0] KNOWN_ALL     = 3'b111;

    localparam longint ONE_Q      = longint'(1) << FRACTION_BITS;
    localparam longint QUAD_COEF  = (4 * ONE_Q + 50) / 100;       // 0.04, nearest
    localparam longint OPER_LIMIT = (longint'(1) << 46) - 1;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam int     SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int     GAIN_NOM   = 382463;

    // settle margin after the last predicted result is out
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_REPORTS   = 10;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [9:0] adc_sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [0] spike, [32:1] membrane, [64:33] recovery
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    spiking_neuron_from_sensor_slope_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Neuron predictor: its own copy of the registers and state.
    // Register and state values held as 64-bit signed integers; all
    // products fit since operands are clamped to 47 bits before scaling.
    // ------------------------------------------------------------------
    longint gain_q  = (longint'(1000) << FRACTION_BITS) * 10000 / 1713525;
    longint dt_q    = (5 * ONE_Q + 50) / 100;
    longint a_q     = (2 * ONE_Q + 50) / 100;
    longint b_q     = (20 * ONE_Q + 50) / 100;
    longint c_q     = -65 * ONE_Q;
    longint d_q     = 8 * ONE_Q;
    longint thr_q   = 30 * ONE_Q;
    longint floor_q = -30 * ONE_Q;

    logic [9:0] nrn_prev = 10'((66 * SAMPLE_MAX + 50) / 100);   // 3.3 V of 5 V
    longint     nrn_v    = -30 * ONE_Q;
    longint     nrn_u    = 0;

    neuron_out_t pending_steps [$];   // predicted results, oldest first
    int          fail_count = 0;
    bit          quiet      = 1'b0;   // no idling on either side while set

    // x times an unsigned fixed-point coefficient, x clamped first, floor
    function automatic longint scale_q(input longint x, input longint coef);
        longint xc;
        xc = x;
        if (xc > OPER_LIMIT)  xc = OPER_LIMIT;
        if (xc < -OPER_LIMIT) xc = -OPER_LIMIT;
        return (xc * coef) >>> FRACTION_BITS;
    endfunction

    function automatic longint sat_word(input longint x);
        if (x > WORD_MAX) return WORD_MAX;
        if (x < WORD_MIN) return WORD_MIN;
        return x;
    endfunction

    // one forward-Euler step; advances the predictor state
    function automatic neuron_out_t euler_step(input logic [9:0] smp);
        longint      v, u, cur, quad, sum, vn, un;
        neuron_out_t r;
        v        = nrn_v;
        u        = nrn_u;
        cur      = gain_q * (longint'(smp) - longint'(nrn_prev));
        nrn_prev = smp;
        quad     = (((QUAD_COEF * v) >>> FRACTION_BITS) * v) >>> FRACTION_BITS;
        sum      = quad + 5 * v + 140 * ONE_Q - u + cur;
        vn       = sat_word(v + scale_q(sum, dt_q));
        un       = sat_word(u + scale_q(scale_q(scale_q(v, b_q) - u, a_q), dt_q));
        if (vn < floor_q) vn = floor_q;
        r.spike = 1'b0;
        if (vn >= thr_q) begin
            vn      = c_q;
            un      = sat_word(un + d_q);
            r.spike = 1'b1;
        end
        nrn_v      = vn;
        nrn_u      = un;
        r.membrane = vn[31:0];
        r.recovery = un[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic row_t sample_row(input logic [9:0] smp, input logic [2:0] known,
                                        input logic spk, input logic signed [31:0] v,
                                        input logic signed [31:0] u);
        row_t r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.sample = smp;
        r.known  = known;
        r.want   = '{spk, v, u};
        return r;
    endfunction

    function automatic row_t reg_row(input cfg_idx_t idx, input logic [23:0] val);
        row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    // register value for a random phase
    function automatic logic [23:0] reg_value(input cfg_idx_t idx, input profile_t p);
        logic [23:0] val;
        bit          hi;
        bit          ext;
        hi  = 1'($urandom_range(1));
        ext = (p == PROF_EXTREME);
        val = 24'($urandom);
        if (p != PROF_RANDOM) begin
            case (idx)
                CFG_GAIN:      val = ext ? (hi ? 24'd8388607 : 24'd0)
                                         : 24'($urandom_range(2 * GAIN_NOM));
                CFG_STEP:      val = ext ? (hi ? 24'd65536 : 24'd1)
                                         : 24'($urandom_range(1000, 8000));
                CFG_RATE:      val = ext ? (hi ? 24'd65536 : 24'd0)
                                         : 24'($urandom_range(8000));
                CFG_SENS:      val = ext ? (hi ? 24'd65536 : 24'd0)
                                         : 24'($urandom_range(30000));
                CFG_RESET_POT: val = ext ? (hi ? 24'd0 : 24'h800000)
                                         : 24'(-int'($urandom_range(40, 80)) * 65536);
                CFG_JUMP:      val = ext ? (hi ? 24'd2097152 : 24'd0)
                                         : 24'($urandom_range(16) * 65536);
                CFG_THRESHOLD: val = ext ? (hi ? 24'd8388608 : 24'd0)
                                         : 24'($urandom_range(10, 40) * 65536);
                CFG_FLOOR:     val = ext ? (hi ? 24'd0 : 24'h800000)
                                         : 24'(-int'($urandom_range(20, 90)) * 65536);
                default: ;
            endcase
        end
        return val;
    endfunction

    // hold off requests until every predicted result is out, plus margin
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write; cfg_we is lowered by the next request or the end
    task automatic write_register(input cfg_idx_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_GAIN:      gain_q  = longint'(val[22:0]);
            CFG_STEP:      dt_q    = longint'(val[16:0]);
            CFG_RATE:      a_q     = longint'(val[16:0]);
            CFG_SENS:      b_q     = longint'(val[16:0]);
            CFG_RESET_POT: c_q     = longint'($signed(val));
            CFG_JUMP:      d_q     = longint'(val[21:0]);
            CFG_THRESHOLD: thr_q   = longint'(val);
            CFG_FLOOR:     floor_q = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // issue one sample request; typed fields override the prediction
    task automatic issue_sample(input logic [9:0] smp, input logic [2:0] known,
                                input neuron_out_t typed);
        neuron_out_t want;
        cfg_we <= 1'b0;
        // sender gap, random length so it lands on every phase of the step
        if (!quiet && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        do @(posedge aclk); while (!s_tready);
        want = euler_step(smp);
        if (known[0]) want.spike    = typed.spike;
        if (known[1]) want.membrane = typed.membrane;
        if (known[2]) want.recovery = typed.recovery;
        pending_steps.push_back(want);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, in-order compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin : result_check
        neuron_out_t want;
        neuron_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[32:1], m_tdata[64:33]};
            if (pending_steps.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: spike %0d membrane %0d recovery %0d",
                             got.spike, got.membrane, got.recovery);
                fail_count++;
            end else begin
                want = pending_steps.pop_front();
                if (got !== want) begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: spike %0d/%0d membrane %0d/%0d recovery %0d/%0d",
                                 want.spike, got.spike, want.membrane, got.membrane,
                                 want.recovery, got.recovery);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        row_t     directed_rows [$];
        bit       in_reg_run;
        profile_t prof;
        int       walk;
        int       pick;

        // after reset, flat input: v = -30 drifts up, u goes slightly negative
        directed_rows.push_back(sample_row(10'd675, KNOWN_ALL, 1'b0, -32'sd1880898, -32'sd394));
        // steepest rise and fall of the sensor
        directed_rows.push_back(sample_row(10'd1023, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd0, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd0, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd1023, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd512, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        // floor and threshold both zero: every step fires, v lands on c
        directed_rows.push_back(reg_row(CFG_THRESHOLD, 24'd0));
        directed_rows.push_back(reg_row(CFG_FLOOR, 24'd0));
        directed_rows.push_back(sample_row(10'd512, KNOWN_SPIKE_V, 1'b1, -32'sd4259840, 32'sd0));
        directed_rows.push_back(sample_row(10'd0, KNOWN_SPIKE_V, 1'b1, -32'sd4259840, 32'sd0));
        // lowest reset potential, recovery jump of 32
        directed_rows.push_back(reg_row(CFG_RESET_POT, 24'h800000));
        directed_rows.push_back(reg_row(CFG_JUMP, 24'd2097152));
        directed_rows.push_back(sample_row(10'd1023, KNOWN_SPIKE_V, 1'b1, -32'sd8388608, 32'sd0));
        directed_rows.push_back(sample_row(10'd1023, KNOWN_SPIKE_V, 1'b1, -32'sd8388608, 32'sd0));
        // full gain, unit coefficients, threshold 128 and lowest floor
        directed_rows.push_back(reg_row(CFG_THRESHOLD, 24'd8388608));
        directed_rows.push_back(reg_row(CFG_FLOOR, 24'h800000));
        directed_rows.push_back(reg_row(CFG_GAIN, 24'd8388607));
        directed_rows.push_back(reg_row(CFG_STEP, 24'd65536));
        directed_rows.push_back(reg_row(CFG_RATE, 24'd65536));
        directed_rows.push_back(reg_row(CFG_SENS, 24'd65536));
        // full fall: v saturates low, then is raised to the floor
        directed_rows.push_back(sample_row(10'd0, KNOWN_SPIKE_V, 1'b0, -32'sd8388608, 32'sd0));
        // full rise: v saturates high and fires
        directed_rows.push_back(sample_row(10'd1023, KNOWN_SPIKE_V, 1'b1, -32'sd8388608, 32'sd0));
        directed_rows.push_back(sample_row(10'd1023, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        // coefficients past range (about 2): u oscillates, grows and saturates
        directed_rows.push_back(reg_row(CFG_STEP, 24'h01FFFF));
        directed_rows.push_back(reg_row(CFG_RATE, 24'h01FFFF));
        directed_rows.push_back(reg_row(CFG_SENS, 24'd0));
        directed_rows.push_back(reg_row(CFG_GAIN, 24'd0));
        directed_rows.push_back(sample_row(10'd300, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd301, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd700, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd699, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd0, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd5, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd1023, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));
        directed_rows.push_back(sample_row(10'd1000, KNOWN_NONE, 1'b0, 32'sd0, 32'sd0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; consecutive register rows share one drain
        in_reg_run = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                if (!in_reg_run) drain_pipeline();
                write_register(directed_rows[i].reg_idx, directed_rows[i].value);
                in_reg_run = 1'b1;
            end else begin
                issue_sample(directed_rows[i].sample, directed_rows[i].known,
                             directed_rows[i].want);
                in_reg_run = 1'b0;
            end
        end

        // random phases: new register set each phase, sensor mostly a
        // slow random walk with occasional jumps and rail hits
        walk = int'(nrn_prev);
        for (int ph = 0; ph < PHASES; ph++) begin
            pick = $urandom_range(9);
            if (ph == 0)      prof = PROF_NOMINAL;
            else if (ph == 1) prof = PROF_EXTREME;
            else if (pick < 6) prof = PROF_NOMINAL;
            else if (pick < 8) prof = PROF_RANDOM;
            else               prof = PROF_EXTREME;
            drain_pipeline();
            quiet = (ph == 6 || ph == 7);
            for (int r = 0; r < 8; r++) write_register(cfg_idx_t'(r), reg_value(cfg_idx_t'(r), prof));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    walk = walk + int'($urandom_range(40)) - 20;
                    if (walk < 0)          walk = 0;
                    if (walk > SAMPLE_MAX) walk = SAMPLE_MAX;
                end else if (pick < 95) begin
                    walk = $urandom_range(SAMPLE_MAX);
                end else begin
                    walk = $urandom_range(1) ? SAMPLE_MAX : 0;
                end
                issue_sample(10'(walk), KNOWN_NONE, '0);
            end
        end
        quiet = 1'b0;

        cfg_we   <= 1'b0;
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_steps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sns_pkg.sv
rtl/core/sns_mul.sv
rtl/core/sns_seq.sv
rtl/core/spiking_neuron_from_sensor_slope_top.sv
tb/spiking_neuron_from_sensor_slope_top_tb.sv
